[hw/rtl/asgr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_pkg
// Shared constants, types and the replacement text table of the SGR escape
// stripper.
// ----------------------------------------------------------------------------
package asgr_pkg;

  // Largest number of parameter bytes held for one open sequence.
  localparam int unsigned MAX_PARAM_CHARS = 16;

  // Byte codes that the scanner looks for.
  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] LBR_BYTE   = 8'h5B;  // '['
  localparam logic [7:0] M_BYTE     = 8'h6D;  // 'm'
  localparam logic [7:0] SEMI_BYTE  = 8'h3B;  // ';'
  localparam logic [7:0] DIGIT_LO   = 8'h30;  // '0'
  localparam logic [7:0] DIGIT_HI   = 8'h39;  // '9'

  // The text that stands for an ESC of a broken sequence.
  localparam int unsigned   ESC_TEXT_LEN = 5;
  localparam logic [2:0]    ESC_TEXT_LAST = 3'(ESC_TEXT_LEN - 1);

  // Source of the byte that goes into the output register.
  typedef enum logic [2:0] {
    SEL_TXT,
    SEL_ESC,
    SEL_LBR,
    SEL_PEND,
    SEL_CHR,
    SEL_MARK
  } sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;       // capture the accepted byte
    logic append;    // store the accepted byte in the parameter buffer
    logic clr_cnt;   // empty the parameter buffer
    logic txt_rst;   // restart the replacement text index
    logic txt_inc;   // step the replacement text index
    logic ptr_rst;   // restart the buffer read pointer
    logic ptr_inc;   // step the buffer read pointer
    logic emit;      // load a beat into the output register
    sel_e sel;       // byte source of that beat
    logic last;      // the beat closes the message
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_esc;     // incoming byte is ESC
    logic is_lbr;     // incoming byte is '['
    logic is_m;       // incoming byte is 'm'
    logic is_param;   // incoming byte is a digit or ';'
    logic msg_end;    // incoming byte ends the message
    logic full;       // parameter buffer holds its maximum
    logic cnt_empty;  // parameter buffer is empty
    logic pend_last;  // read pointer is at the last buffered byte
    logic txt_last;   // text index is at the last character
    logic slot_free;  // output register can take a beat
  } sts_t;

  // Characters of the replacement text "<ESC>".
  function automatic logic [7:0] esc_text_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h3C;  // '<'
      3'd1:    ch = 8'h45;  // 'E'
      3'd2:    ch = 8'h53;  // 'S'
      3'd3:    ch = 8'h43;  // 'C'
      3'd4:    ch = 8'h3E;  // '>'
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[hw/rtl/asgr_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_in_if
// Input channel: one message byte per beat with an end of message flag.
// ----------------------------------------------------------------------------
interface asgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       msg_end;

  modport source (output valid, output char_in, output msg_end, input ready);
  modport sink   (input valid, input char_in, input msg_end, output ready);
endinterface

[hw/rtl/asgr_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_out_if
// Output channel: one result byte or end marker per beat.
// ----------------------------------------------------------------------------
interface asgr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       has_char;
  logic       out_last;

  modport source (output valid, output char_out, output has_char, output out_last,
                  input ready);
  modport sink   (input valid, input char_out, input has_char, input out_last,
                  output ready);
endinterface

[hw/rtl/asgr_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_datapath
// Byte classification, parameter buffer, read pointer, text index and the
// output register of the SGR escape stripper.
// ----------------------------------------------------------------------------
module asgr_datapath #(
  parameter int unsigned MaxParamChars = asgr_pkg::MAX_PARAM_CHARS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       char_in_i,
  input  logic             msg_end_i,
  input  asgr_pkg::cmd_t   cmd_i,
  output asgr_pkg::sts_t   sts_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       char_out_o,
  output logic             has_char_o,
  output logic             out_last_o
);
  import asgr_pkg::*;

  localparam int unsigned CntW = $clog2(MaxParamChars + 1);
  localparam int unsigned IdxW = (MaxParamChars > 1) ? $clog2(MaxParamChars) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MaxParamChars);

  logic [7:0]      char_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [2:0]      txt_q, txt_d;
  logic [7:0]      pend_mem [MaxParamChars];
  logic [7:0]      rd_q;
  logic            out_valid_q;
  logic [7:0]      char_out_q;
  logic            has_char_q;
  logic            out_last_q;
  logic [7:0]      beat_char;

  // Classification of the byte on the input.
  always_comb begin
    sts_o.is_esc    = (char_in_i == ESC_BYTE);
    sts_o.is_lbr    = (char_in_i == LBR_BYTE);
    sts_o.is_m      = (char_in_i == M_BYTE);
    sts_o.is_param  = ((char_in_i >= DIGIT_LO) && (char_in_i <= DIGIT_HI)) ||
                      (char_in_i == SEMI_BYTE);
    sts_o.msg_end   = msg_end_i;
    sts_o.full      = (cnt_q == CntMax);
    sts_o.cnt_empty = (cnt_q == '0);
    sts_o.pend_last = (ptr_q == CntW'(cnt_q - 1'b1));
    sts_o.txt_last  = (txt_q == ESC_TEXT_LAST);
    sts_o.slot_free = !out_valid_q || out_ready_i;
  end

  // Counters and pointers.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clr_cnt) begin
      cnt_d = '0;
    end else if (cmd_i.append) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end
    ptr_d = ptr_q;
    if (cmd_i.ptr_rst) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = CntW'(ptr_q + 1'b1);
    end
    txt_d = txt_q;
    if (cmd_i.txt_rst) begin
      txt_d = '0;
    end else if (cmd_i.txt_inc) begin
      txt_d = 3'(txt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
      txt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      txt_q <= txt_d;
    end
  end

  // Accepted byte.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      char_q <= char_in_i;
    end
  end

  // Parameter buffer; the read is addressed by the next pointer value, so rd_q holds the entry at the pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      pend_mem[cnt_q[IdxW-1:0]] <= char_in_i;
    end
    if (ptr_d < CntMax) begin
      rd_q <= pend_mem[ptr_d[IdxW-1:0]];
    end
  end

  // Byte of the next beat.
  always_comb begin
    unique case (cmd_i.sel)
      SEL_TXT:  beat_char = esc_text_char(txt_q);
      SEL_ESC:  beat_char = ESC_BYTE;
      SEL_LBR:  beat_char = LBR_BYTE;
      SEL_PEND: beat_char = rd_q;
      SEL_CHR:  beat_char = char_q;
      SEL_MARK: beat_char = 8'h00;
      default:  beat_char = 8'h00;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_out_q <= beat_char;
      has_char_q <= (cmd_i.sel != SEL_MARK);
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_out_q;
  assign has_char_o  = has_char_q;
  assign out_last_o  = out_last_q;

endmodule

[hw/rtl/asgr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_ctrl
// Scan mode tracking and the sequencer that issues the result beats of one
// accepted byte.
// ----------------------------------------------------------------------------
module asgr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  asgr_pkg::sts_t sts_i,
  output asgr_pkg::cmd_t cmd_o
);
  import asgr_pkg::*;

  // Scan modes.
  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_AFTER_ESC = 2'd1;
  localparam logic [1:0] MODE_INSIDE    = 2'd2;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TXT  = 3'd1;
  localparam logic [2:0] ST_ESC  = 3'd2;
  localparam logic [2:0] ST_BRK  = 3'd3;
  localparam logic [2:0] ST_PEND = 3'd4;
  localparam logic [2:0] ST_CHR  = 3'd5;
  localparam logic [2:0] ST_TAIL = 3'd6;
  localparam logic [2:0] ST_MARK = 3'd7;

  // Outstanding work of the current byte, in emission order.
  typedef struct packed {
    logic txt;
    logic esc;
    logic brk;
    logic chr;
    logic tail;
    logic mark;
  } flags_t;

  logic [2:0] state_q, state_d;
  logic [1:0] mode_q, mode_d;
  flags_t     flags_q, flags_d;
  flags_t     flags_new, flags_after;
  logic       end_q, end_d;
  logic       consumed;
  logic       done_here;

  function automatic logic [2:0] pick(input flags_t f);
    logic [2:0] s;
    if (f.txt) begin
      s = ST_TXT;
    end else if (f.esc) begin
      s = ST_ESC;
    end else if (f.brk) begin
      s = ST_BRK;
    end else if (f.chr) begin
      s = ST_CHR;
    end else if (f.tail) begin
      s = ST_TAIL;
    end else if (f.mark) begin
      s = ST_MARK;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);

  // Decode of an accepted byte against the current mode.
  always_comb begin
    flags_new = '0;
    mode_d    = mode_q;
    consumed  = 1'b0;
    cmd_o     = '0;
    cmd_o.sel = SEL_CHR;
    unique case (mode_q)
      MODE_AFTER_ESC: begin
        if (sts_i.is_lbr) begin
          mode_d        = MODE_INSIDE;
          cmd_o.clr_cnt = 1'b1;
          consumed      = 1'b1;
        end else begin
          flags_new.esc = 1'b1;
          mode_d        = MODE_NORMAL;
        end
      end
      MODE_INSIDE: begin
        if (sts_i.is_m) begin
          mode_d   = MODE_NORMAL;
          consumed = 1'b1;
        end else if (sts_i.is_param) begin
          if (!sts_i.full) begin
            cmd_o.append = 1'b1;
            consumed     = 1'b1;
          end else begin
            // Buffer overflow: the sequence goes out raw.
            flags_new.esc = 1'b1;
            flags_new.brk = 1'b1;
            mode_d        = MODE_NORMAL;
          end
        end else begin
          // A foreign byte breaks the sequence: ESC is shown as text.
          flags_new.txt = 1'b1;
          flags_new.brk = 1'b1;
          mode_d        = MODE_NORMAL;
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
      end
    endcase

    if (!consumed) begin
      if (sts_i.is_esc) begin
        mode_d = MODE_AFTER_ESC;
      end else begin
        flags_new.chr = 1'b1;
      end
    end

    // Message end closes whatever is still open.
    if (sts_i.msg_end) begin
      if (mode_d == MODE_AFTER_ESC) begin
        flags_new.tail = 1'b1;
      end else if (mode_d == MODE_INSIDE) begin
        flags_new.esc = 1'b1;
        flags_new.brk = 1'b1;
      end
      mode_d = MODE_NORMAL;
      flags_new.mark = (flags_new == '0);
    end

    // Sequencer.
    state_d     = state_q;
    flags_d     = flags_q;
    end_d       = end_q;
    flags_after = flags_q;
    done_here   = 1'b1;
    unique case (state_q)
      ST_TXT:  begin
        flags_after.txt = !sts_i.txt_last;
        done_here       = sts_i.txt_last;
        cmd_o.sel       = SEL_TXT;
      end
      ST_ESC:  begin
        flags_after.esc = 1'b0;
        cmd_o.sel       = SEL_ESC;
      end
      ST_BRK:  begin
        flags_after.brk = 1'b0;
        cmd_o.sel       = SEL_LBR;
      end
      ST_PEND: begin
        done_here = sts_i.pend_last;
        cmd_o.sel = SEL_PEND;
      end
      ST_CHR:  begin
        flags_after.chr = 1'b0;
        cmd_o.sel       = SEL_CHR;
      end
      ST_TAIL: begin
        flags_after.tail = 1'b0;
        cmd_o.sel        = SEL_ESC;
      end
      ST_MARK: begin
        flags_after.mark = 1'b0;
        cmd_o.sel        = SEL_MARK;
      end
      default: begin
        flags_after = flags_q;
      end
    endcase

    if (state_q == ST_IDLE) begin
      // The mode decode only takes effect for an accepted beat.
      if (in_valid_i) begin
        cmd_o.cap     = 1'b1;
        cmd_o.txt_rst = 1'b1;
        cmd_o.ptr_rst = 1'b1;
        flags_d       = flags_new;
        end_d         = sts_i.msg_end;
        state_d       = pick(flags_new);
      end else begin
        mode_d        = mode_q;
        cmd_o.clr_cnt = 1'b0;
        cmd_o.append  = 1'b0;
      end
    end else begin
      mode_d        = mode_q;
      cmd_o.clr_cnt = 1'b0;
      cmd_o.append  = 1'b0;
      if (sts_i.slot_free) begin
        cmd_o.emit    = 1'b1;
        cmd_o.txt_inc = (state_q == ST_TXT);
        cmd_o.ptr_inc = (state_q == ST_PEND);
        flags_d       = flags_after;
        if (done_here) begin
          if ((state_q == ST_BRK) && !sts_i.cnt_empty) begin
            state_d = ST_PEND;
          end else begin
            state_d    = pick(flags_after);
            cmd_o.last = end_q && (flags_after == '0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_NORMAL;
      flags_q <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      flags_q <= flags_d;
      end_q   <= end_d;
    end
  end

endmodule

[hw/rtl/ansi_sgr_escape_stripper_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_escape_stripper_unit
// Removes ESC [ {digit|;}* m color sequences from a message byte stream.
// ----------------------------------------------------------------------------
// Bytes enter one per beat, with msg_end on the last byte of a message.
// A complete SGR sequence is dropped; a broken one comes out with its ESC
// written as the text "<ESC>", and an overlong or unfinished one comes out
// raw. Every message produces at least one beat, the last one flagged by
// out_last (an end marker with has_char low if no byte remains). A byte is
// taken only while the single result sequencer is idle; it then issues the
// result beats the byte causes, one per cycle while the output register can
// take a beat, walking the parameter buffer one entry per cycle. No new byte
// is taken until the last of those beats is issued. A full output register
// stalls the sequencer until the sink takes its beat.
module ansi_sgr_escape_stripper_unit #(
  parameter int unsigned MaxParamChars = asgr_pkg::MAX_PARAM_CHARS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  asgr_in_if.sink      in_if,
  asgr_out_if.source   out_if
);
  import asgr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  asgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  asgr_datapath #(
    .MaxParamChars (MaxParamChars)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_in_i   (in_if.char_in),
    .msg_end_i   (in_if.msg_end),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .char_out_o  (out_if.char_out),
    .has_char_o  (out_if.has_char),
    .out_last_o  (out_if.out_last)
  );

endmodule
